// File: rtl/sae_pkg.sv
// Shared types and defaults for the stack allocator engine.
// Holds the command and status codes and the request and response word structs.
// No dependencies.
package sae_pkg;

   localparam int SAE_CAPACITY     = 65536;
   localparam int SAE_MAX_LIVE     = 64;
   localparam int SAE_HEADER_BYTES = 8;
   localparam int SAE_MAX_ALIGN    = 4096;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_REALLOC = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOSPACE  = 3'd1,
      ST_NOTTOP   = 3'd2,
      ST_BADALIGN = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [16:0] req_size;
      logic [12:0] align_bytes;
      logic [15:0] offset_in;
      logic        offset_present;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] offset_out;
      logic        offset_valid;
      logic [16:0] bytes_used;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clr;
   } hdr_op_type;

endpackage

// File: rtl/sae_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sae_hdr_stack.sv
// Header stack of the allocator: live count, newest entry in registers, the rest in RAM.
// Depends on sae_pkg and sae_ram.
module sae_hdr_stack #(
   parameter int MAX_LIVE = 64,
   parameter int GAP_W    = 17,
   parameter int PAD_W    = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sae_pkg::hdr_op_type             op,
   input  logic [GAP_W-1:0]                push_gap,
   input  logic [PAD_W-1:0]                push_pad,
   output logic [$clog2(MAX_LIVE+1)-1:0]   live,
   output logic [GAP_W-1:0]                top_gap,
   output logic [PAD_W-1:0]                top_pad
);
   import sae_pkg::*;

   localparam int LW = $clog2(MAX_LIVE + 1);
   localparam int AW = $clog2(MAX_LIVE);
   localparam int EW = GAP_W + PAD_W;

   logic [LW-1:0]    live_ff, live_in;
   logic [GAP_W-1:0] top_gap_ff, top_gap_in;
   logic [PAD_W-1:0] top_pad_ff, top_pad_in;
   logic             fwd_valid_ff, fwd_valid_in;
   logic [EW-1:0]    fwd_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [EW-1:0]    wr_data, rd_data, below;
   logic [LW-1:0]    live_m1, live_in_m2;

   assign live_m1    = live_ff - LW'(1);
   assign live_in_m2 = live_in - LW'(2);
   assign wr_en      = op.push && (live_ff != '0);
   assign wr_addr    = live_m1[AW-1:0];
   assign wr_data    = {top_gap_ff, top_pad_ff};
   assign rd_addr    = (live_in >= LW'(2)) ? live_in_m2[AW-1:0] : '0;
   assign fwd_valid_in = wr_en && (wr_addr == rd_addr);
   assign below      = fwd_valid_ff ? fwd_data_ff : rd_data;

   always_comb begin
      live_in    = live_ff;
      top_gap_in = top_gap_ff;
      top_pad_in = top_pad_ff;
      priority if (op.clr) begin
         live_in = '0;
      end else if (op.push) begin
         live_in    = live_ff + LW'(1);
         top_gap_in = push_gap;
         top_pad_in = push_pad;
      end else if (op.pop) begin
         live_in    = live_m1;
         top_gap_in = below[EW-1:PAD_W];
         top_pad_in = below[PAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         live_ff      <= live_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      top_gap_ff  <= top_gap_in;
      top_pad_ff  <= top_pad_in;
      fwd_data_ff <= wr_data;
   end

   sae_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_LIVE)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign live    = live_ff;
   assign top_gap = top_gap_ff;
   assign top_pad = top_pad_ff;

endmodule

// File: rtl/sae_plan.sv
// Decision logic of the allocator: padding, space checks and the next state for one word.
// Depends on sae_pkg.
module sae_plan #(
   parameter int CAPACITY     = 65536,
   parameter int MAX_LIVE     = 64,
   parameter int HEADER_BYTES = 8,
   parameter int MAX_ALIGN    = 4096
) (
   input  sae_pkg::req_type                                   item,
   input  logic [$clog2(CAPACITY+1)-1:0]                      fill,
   input  logic [$clog2(CAPACITY+1)-1:0]                      top_start,
   input  logic [$clog2(MAX_LIVE+1)-1:0]                      live,
   input  logic [$clog2(CAPACITY+1)-1:0]                      top_gap,
   input  logic [$clog2(MAX_ALIGN+HEADER_BYTES+1)-1:0]        top_pad,
   output logic [$clog2(CAPACITY+1)-1:0]                      fill_next,
   output logic [$clog2(CAPACITY+1)-1:0]                      top_start_next,
   output sae_pkg::hdr_op_type                                op,
   output logic [$clog2(CAPACITY+1)-1:0]                      push_gap,
   output logic [$clog2(MAX_ALIGN+HEADER_BYTES+1)-1:0]        push_pad,
   output sae_pkg::rsp_type                                   rsp
);
   import sae_pkg::*;

   localparam int FW = $clog2(CAPACITY + 1);
   localparam int LW = $clog2(MAX_LIVE + 1);
   localparam int PW = $clog2(MAX_ALIGN + HEADER_BYTES + 1);
   localparam int WW = ((FW > 17) ? FW : 17) + 3;

   logic [WW-1:0] a_w, am1, fill_w, size_w, where_w;
   logic [WW-1:0] m, pad0, need, pad, start, alloc_end, top_off, place_end;
   logic          align_ok, full, alloc_nospace, has_top, is_top;
   status_type    alloc_st;

   assign a_w     = WW'(item.align_bytes);
   assign am1     = a_w - WW'(1);
   assign fill_w  = WW'(fill);
   assign size_w  = WW'(item.req_size);
   assign where_w = WW'(item.offset_in);

   assign align_ok = (item.align_bytes != '0)
                  && ((item.align_bytes & (item.align_bytes - 13'd1)) == '0)
                  && (a_w <= WW'(MAX_ALIGN));
   assign full     = (live == LW'(MAX_LIVE));

   assign m     = fill_w & am1;
   assign pad0  = (a_w - m) & am1;
   assign need  = WW'(HEADER_BYTES) - pad0;
   assign pad   = (pad0 < WW'(HEADER_BYTES)) ? (pad0 + ((need + am1) & ~am1)) : pad0;
   assign start = fill_w + pad;
   assign alloc_end     = start + size_w;
   assign alloc_nospace = (start > WW'(16'hFFFF)) || (alloc_end > WW'(CAPACITY));

   assign has_top   = (live != '0);
   assign top_off   = WW'(top_start) + WW'(top_pad);
   assign is_top    = has_top && (top_off == where_w);
   assign place_end = where_w + size_w;

   always_comb begin
      priority if (!align_ok) begin
         alloc_st = ST_BADALIGN;
      end else if (full) begin
         alloc_st = ST_FULL;
      end else if (alloc_nospace) begin
         alloc_st = ST_NOSPACE;
      end else begin
         alloc_st = ST_OK;
      end
   end

   always_comb begin
      logic do_alloc;
      logic do_free;
      do_alloc = 1'b0;
      do_free  = 1'b0;
      fill_next      = fill;
      top_start_next = top_start;
      op             = '0;
      push_gap       = fill - top_start;
      push_pad       = PW'(pad);
      rsp.status       = ST_OK;
      rsp.offset_out   = '0;
      rsp.offset_valid = 1'b0;

      unique case (item.cmd)
         CMD_ALLOC: begin
            do_alloc = 1'b1;
         end
         CMD_FREE: begin
            do_free = 1'b1;
         end
         CMD_REALLOC: begin
            priority if (!item.offset_present) begin
               do_alloc = 1'b1;
            end else if (item.req_size == '0) begin
               do_free = 1'b1;
            end else if (is_top) begin
               if (place_end > WW'(CAPACITY)) begin
                  rsp.status = ST_NOSPACE;
               end else begin
                  fill_next        = FW'(place_end);
                  rsp.offset_out   = item.offset_in;
                  rsp.offset_valid = 1'b1;
               end
            end else begin
               do_alloc = 1'b1;
            end
         end
         CMD_CLEAR: begin
            fill_next      = '0;
            top_start_next = '0;
            op.clr         = 1'b1;
         end
      endcase

      if (do_alloc) begin
         rsp.status = alloc_st;
         if (alloc_st == ST_OK) begin
            op.push          = 1'b1;
            top_start_next   = fill;
            fill_next        = FW'(alloc_end);
            rsp.offset_out   = start[15:0];
            rsp.offset_valid = 1'b1;
         end
      end

      if (do_free && item.offset_present) begin
         if (is_top) begin
            op.pop         = 1'b1;
            fill_next      = top_start;
            top_start_next = top_start - top_gap;
         end else begin
            rsp.status = ST_NOTTOP;
         end
      end

      rsp.bytes_used = 17'(fill_next);
   end

endmodule

// File: rtl/stack_allocator_engine.sv
// Stack allocator engine: a bump allocator with aligned, header-padded allocations over a
// fixed region. An accepted word is registered, decided combinationally against the fill
// level, the newest header and the live count, and its response word is registered; the
// response register holds it while the output is stalled. One word is taken every cycle
// while the output is not stalled: the loop that sets this rate is the update of fill
// level, top start and header stack. Headers below the newest live in a RAM read one entry
// below the top with the newest header kept in registers, so a free never waits for the
// RAM. The header RAM needs no clearing pass; the block is ready straight after reset.
// Depends on sae_pkg, sae_plan, sae_hdr_stack and sae_ram.
module stack_allocator_engine #(
   parameter int CAPACITY     = sae_pkg::SAE_CAPACITY,
   parameter int MAX_LIVE     = sae_pkg::SAE_MAX_LIVE,
   parameter int HEADER_BYTES = sae_pkg::SAE_HEADER_BYTES,
   parameter int MAX_ALIGN    = sae_pkg::SAE_MAX_ALIGN
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sae_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sae_pkg::rsp_type rsp_word
);
   import sae_pkg::*;

   localparam int FW = $clog2(CAPACITY + 1);
   localparam int LW = $clog2(MAX_LIVE + 1);
   localparam int PW = $clog2(MAX_ALIGN + HEADER_BYTES + 1);

   logic          in_valid_ff, in_valid_in;
   req_type       in_word_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_word_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] top_start_ff, top_start_in;
   logic          advance;

   logic [FW-1:0] fill_next, top_start_next, push_gap, top_gap;
   logic [PW-1:0] push_pad, top_pad;
   logic [LW-1:0] live;
   hdr_op_type    plan_op, hdr_op;
   rsp_type       plan_rsp;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign fill_in      = advance ? fill_next : fill_ff;
   assign top_start_in = advance ? top_start_next : top_start_ff;
   assign hdr_op       = advance ? plan_op : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         top_start_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         top_start_ff <= top_start_in;
      end
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= plan_rsp;
      end
   end

   sae_plan #(
      .CAPACITY    (CAPACITY),
      .MAX_LIVE    (MAX_LIVE),
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_ALIGN   (MAX_ALIGN)
   ) u_plan (
      .item          (in_word_ff),
      .fill          (fill_ff),
      .top_start     (top_start_ff),
      .live          (live),
      .top_gap       (top_gap),
      .top_pad       (top_pad),
      .fill_next     (fill_next),
      .top_start_next(top_start_next),
      .op            (plan_op),
      .push_gap      (push_gap),
      .push_pad      (push_pad),
      .rsp           (plan_rsp)
   );

   sae_hdr_stack #(
      .MAX_LIVE(MAX_LIVE),
      .GAP_W   (FW),
      .PAD_W   (PW)
   ) u_hdr_stack (
      .clock   (clock),
      .reset   (reset),
      .op      (hdr_op),
      .push_gap(push_gap),
      .push_pad(push_pad),
      .live    (live),
      .top_gap (top_gap),
      .top_pad (top_pad)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: rtl/sae_checker.sv
// Port-level checks on the stack allocator engine, attached to the top level by bind.
// Depends on sae_pkg and stack_allocator_engine.
module sae_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sae_pkg::rsp_type rsp_word
);
   import sae_pkg::*;

   // A stalled response word holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // Only a successful word names a live allocation.
   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.offset_valid |-> rsp_word.status == ST_OK)
      else $error("offset marked valid on a failed word");

   // A word that names no allocation carries a zero offset.
   a_zero_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.offset_valid |-> rsp_word.offset_out == '0)
      else $error("stray offset on a word without an allocation");

   // A request word that is taken is followed by a waiting response word.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no response word after an accepted request");

   // Reset empties the response side.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stack_allocator_engine sae_checker u_sae_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_word (rsp_word)
);
